// ===== rtl/matrix_multiply_engine_assert.svh =====
// Assertion macros for the matrix multiply engine.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mme_pkg.sv =====
// Shared types and constants of the matrix multiply engine.
// No dependencies; imported by mme_mac and the top level.
package mme_pkg;

    localparam int MAX_DIM    = 64;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_BITS   = $clog2(MAX_DIM);
    localparam int DIM_BITS   = 7;
    localparam int SUM_BITS   = 40;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS  = $clog2(STORE_DEPTH);

    localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);

    typedef enum logic [1:0] {
        REQ_WRITE_A = 2'd0,
        REQ_WRITE_B = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req_kind;

    typedef enum logic [1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic [IDX_BITS-1:0]          row_index;
        logic [IDX_BITS-1:0]          col_index;
        logic signed [ELEM_WIDTH-1:0] elem_value;
    } t_req;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] dot_value;
        logic [IDX_BITS-1:0]        out_row;
        logic [IDX_BITS-1:0]        out_col;
        logic                       range_error;
    } t_res;

    // control from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic clear;
        logic prod_en;
        logic acc_en;
    } t_mac_ctrl;

    // saturate a written dimension to MAX_DIM
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        clamp_dim = (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage

// ===== rtl/mme_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mme_mac.sv =====
// Multiply-accumulate datapath: registered product, exact 40-bit sum.
// Depends on mme_pkg.
module mme_mac import mme_pkg::*; (
    input  logic                         i_clk,
    input  t_mac_ctrl                    i_ctrl,
    input  logic signed [ELEM_WIDTH-1:0] i_a,
    input  logic signed [ELEM_WIDTH-1:0] i_b,
    output logic signed [SUM_BITS-1:0]   o_acc
);

    logic signed [PROD_WIDTH-1:0] r_prod;
    logic signed [SUM_BITS-1:0]   r_acc;
    logic signed [SUM_BITS-1:0]   n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_en) begin
            n_acc = r_acc + SUM_BITS'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_en) begin
            r_prod <= i_a * i_b;
        end
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: request decode, sequencer, stores.
// Depends on mme_pkg, mme_ram, mme_mac and matrix_multiply_engine_assert.svh.
//
// Element writes (A or B) give no result; busy stays low.
// A compute request walks the inner dimension with one multiply-accumulate
// per cycle, read from the two element RAMs at one address each: busy is high
// for the walk and the result word appears in the same cycle that busy
// falls. A compute with a range error, or with inner_dim zero, keeps
// busy low and strobes its result on the next cycle. The result is on o_res
// for exactly one cycle with o_done high and cannot be held off; the next
// request may be started in that same cycle. Configuration writes are always
// ready and belong to idle periods.
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine import mme_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_req                i_req,
    output logic                o_done,
    output t_res                o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [DIM_BITS-1:0] i_cfg_data
);

    t_state              r_state, n_state;
    logic [DIM_BITS-1:0] r_rows_a, r_inner, r_cols_b;
    logic [DIM_BITS-1:0] r_k, n_k;
    logic                r_issuing, n_issuing;
    logic                r_v1, r_v2;
    logic [IDX_BITS-1:0] r_row, n_row, r_col, n_col;
    logic                r_done, n_done;
    t_res                r_res, n_res;

    logic      accept, cfg_we;
    logic      row_ok_a, col_ok_a, row_ok_b, col_ok_b, req_bad;
    logic      wr_a, wr_b, cmp_req, cmp_fast;
    logic      issue, finish;
    t_mac_ctrl mac_ctrl;

    logic [ELEM_WIDTH-1:0]      a_rdata, b_rdata;
    logic signed [SUM_BITS-1:0] acc;
    logic [ADDR_BITS-1:0]       a_raddr, b_raddr, wr_addr;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign accept      = start & ~busy;

    assign row_ok_a = DIM_BITS'(i_req.row_index) < r_rows_a;
    assign col_ok_a = DIM_BITS'(i_req.col_index) < r_inner;
    assign row_ok_b = DIM_BITS'(i_req.row_index) < r_inner;
    assign col_ok_b = DIM_BITS'(i_req.col_index) < r_cols_b;
    assign req_bad  = !(row_ok_a && col_ok_b);

    assign wr_a     = accept && i_req.req_type == REQ_WRITE_A && row_ok_a && col_ok_a;
    assign wr_b     = accept && i_req.req_type == REQ_WRITE_B && row_ok_b && col_ok_b;
    assign cmp_req  = accept && i_req.req_type == REQ_COMPUTE;
    // no walk needed: flagged request or empty inner dimension
    assign cmp_fast = req_bad || r_inner == '0;

    assign wr_addr = {i_req.row_index, i_req.col_index};
    assign a_raddr = {r_row, r_k[IDX_BITS-1:0]};
    assign b_raddr = {r_k[IDX_BITS-1:0], r_col};

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(STORE_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_a),
        .i_waddr (wr_addr),
        .i_wdata (i_req.elem_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(STORE_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_b),
        .i_waddr (wr_addr),
        .i_wdata (i_req.elem_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mme_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (a_rdata),
        .i_b    (b_rdata),
        .o_acc  (acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmp_req && !cmp_fast) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        busy     = 1'b0;
        issue    = 1'b0;
        finish   = 1'b0;
        mac_ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                mac_ctrl.clear = cmp_req;
            end
            ST_RUN: begin
                busy             = 1'b1;
                issue            = r_issuing;
                finish           = !r_issuing && !r_v1 && !r_v2;
                mac_ctrl.prod_en = r_v1;
                mac_ctrl.acc_en  = r_v2;
            end
            default: ;
        endcase
    end

    // walk counter, coordinates and result word
    always_comb begin
        n_k       = r_k;
        n_issuing = r_issuing;
        n_row     = r_row;
        n_col     = r_col;
        n_done    = 1'b0;
        n_res     = r_res;
        if (cmp_req) begin
            n_k       = '0;
            n_issuing = !cmp_fast;
            n_row     = i_req.row_index;
            n_col     = i_req.col_index;
            if (cmp_fast) begin
                n_done            = 1'b1;
                n_res.dot_value   = '0;
                n_res.out_row     = i_req.row_index;
                n_res.out_col     = i_req.col_index;
                n_res.range_error = req_bad;
            end
        end else if (issue) begin
            n_k = r_k + DIM_BITS'(1);
            if (r_k == r_inner - DIM_BITS'(1)) begin
                n_issuing = 1'b0;
            end
        end else if (finish) begin
            n_done            = 1'b1;
            n_res.dot_value   = acc;
            n_res.out_row     = r_row;
            n_res.out_col     = r_col;
            n_res.range_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rows_a  <= DIM_MAX;
            r_inner   <= DIM_MAX;
            r_cols_b  <= DIM_MAX;
            r_issuing <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_v1      <= issue;
            r_v2      <= r_v1;
            r_done    <= n_done;
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS_A:    r_rows_a <= clamp_dim(i_cfg_data);
                    CFG_INNER_DIM: r_inner  <= clamp_dim(i_cfg_data);
                    CFG_COLS_B:    r_cols_b <= clamp_dim(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_row <= n_row;
        r_col <= n_col;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `MME_ASSERT_NOW(a_done_idle, o_done, !busy, "result word strobed while busy")
    `MME_ASSERT_NOW(a_err_zero, o_done && o_res.range_error, o_res.dot_value == '0,
        "range error with nonzero sum")
    `MME_ASSERT_NEXT(a_drain_done, busy && !r_issuing && !r_v1 && !r_v2, o_done && !busy,
        "drained walk gave no result word")
    `MME_ASSERT_NEXT(a_walk_start, cmp_req && !cmp_fast, busy && r_issuing && !o_done,
        "compute request did not start a walk")

endmodule
